/* rtl/core/rsd_pkg.sv */
// rsd_pkg: widths and constants for the RGB saturation (std dev) pipeline.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package rsd_pkg;

	localparam int unsigned PIXW = 8;
	localparam int unsigned DW = 17;
	localparam int unsigned FRACW = 16;
	localparam int unsigned RADW = 2 * (((DW + FRACW) + 1) / 2);
	localparam int unsigned RTW = RADW / 2;
	localparam int unsigned REMW = RTW + 3;
	localparam int unsigned SQRT_STAGES = RTW;
	localparam int unsigned OUTW = 15;
	localparam int unsigned DIV3_SHIFT = 18;
	localparam int unsigned DIV3_MW = 18;
	localparam logic [DIV3_MW-1:0] DIV3_MUL = DIV3_MW'(((1 << DIV3_SHIFT) + 2) / 3);
	localparam int unsigned PRODW = RTW + DIV3_MW;

	typedef logic [PIXW-1:0] pix_t;
	typedef logic [DW-1:0] dsum_t;
	typedef logic [RADW-1:0] rad_t;
	typedef logic [RTW-1:0] root_t;
	typedef logic [REMW-1:0] rem_t;
	typedef logic [OUTW-1:0] res_t;

endpackage

/* rtl/core/rgb_saturation_std_dev.sv */
// rgb_saturation_std_dev: population std dev of one pixel's B, G, R bytes (Q7.8).
// Stages: 1 difference/square stage, 17 square-root digit stages, 2 divide-by-3.
// Throughput one pixel per cycle while result_stall is low; a stall empties no stage and bubbles are squeezed out.
// Asynchronous active-low reset clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps

module rgb_saturation_std_dev (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pixel_valid,
	output logic          pixel_stall,
	input  rsd_pkg::pix_t blue,
	input  rsd_pkg::pix_t green,
	input  rsd_pkg::pix_t red,
	output logic          result_valid,
	input  logic          result_stall,
	output rsd_pkg::res_t std_dev
);
	import rsd_pkg::*;

	logic  ds_rdy, ds_v;
	dsum_t ds_d;

	logic  sq_v   [0:SQRT_STAGES];
	logic  sq_rdy [0:SQRT_STAGES];
	rad_t  sq_rad [0:SQRT_STAGES];
	rem_t  sq_rem [0:SQRT_STAGES];
	root_t sq_root[0:SQRT_STAGES];

	logic  dv_rdy;

	rsd_diff_sq u_diff_sq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (pixel_valid),
		.in_rdy  (ds_rdy),
		.blue    (blue),
		.green   (green),
		.red     (red),
		.out_v   (ds_v),
		.out_rdy (sq_rdy[0]),
		.d       (ds_d)
	);

	assign pixel_stall = !ds_rdy;

	assign sq_v[0] = ds_v;
	assign sq_rad[0] = RADW'({ds_d, {FRACW{1'b0}}});
	assign sq_rem[0] = '0;
	assign sq_root[0] = '0;

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
		rsd_sqrt_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_v     (sq_v[i]),
			.in_rdy   (sq_rdy[i]),
			.rad_in   (sq_rad[i]),
			.rem_in   (sq_rem[i]),
			.root_in  (sq_root[i]),
			.out_v    (sq_v[i+1]),
			.out_rdy  (sq_rdy[i+1]),
			.rad_out  (sq_rad[i+1]),
			.rem_out  (sq_rem[i+1]),
			.root_out (sq_root[i+1])
		);
	end

	assign sq_rdy[SQRT_STAGES] = dv_rdy;

	rsd_div3 u_div3 (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (sq_v[SQRT_STAGES]),
		.in_rdy  (dv_rdy),
		.root    (sq_root[SQRT_STAGES]),
		.out_v   (result_valid),
		.out_rdy (!result_stall),
		.quot    (std_dev)
	);

endmodule

/* rtl/core/rsd_diff_sq.sv */
// rsd_diff_sq: first stage, sum of squared pairwise channel differences.
// 3*(b^2+g^2+r^2) - (b+g+r)^2 == (b-g)^2 + (g-r)^2 + (r-b)^2. Uses rsd_pkg.
`timescale 1ns / 1ps

module rsd_diff_sq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_v,
	output logic          in_rdy,
	input  rsd_pkg::pix_t blue,
	input  rsd_pkg::pix_t green,
	input  rsd_pkg::pix_t red,
	output logic          out_v,
	input  logic          out_rdy,
	output rsd_pkg::dsum_t d
);
	import rsd_pkg::*;

	logic  v_s1;
	dsum_t d_s1;
	pix_t  ad_bg, ad_gr, ad_rb;
	logic [2*PIXW-1:0] sq_bg, sq_gr, sq_rb;
	logic [2*PIXW+1:0] sum;

	always_comb begin
		ad_bg = (blue > green) ? blue - green : green - blue;
		ad_gr = (green > red) ? green - red : red - green;
		ad_rb = (red > blue) ? red - blue : blue - red;
		sq_bg = (2*PIXW)'(ad_bg) * (2*PIXW)'(ad_bg);
		sq_gr = (2*PIXW)'(ad_gr) * (2*PIXW)'(ad_gr);
		sq_rb = (2*PIXW)'(ad_rb) * (2*PIXW)'(ad_rb);
		sum = {2'b00, sq_bg} + {2'b00, sq_gr} + {2'b00, sq_rb};
	end

	assign in_rdy = !v_s1 || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_rdy) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_v) begin
			d_s1 <= sum[DW-1:0];
		end
	end

	assign out_v = v_s1;
	assign d = d_s1;

endmodule

/* rtl/core/rsd_sqrt_stage.sv */
// rsd_sqrt_stage: one digit of a restoring integer square root, registered.
// Consumes two radicand bits per stage. Uses rsd_pkg.
`timescale 1ns / 1ps

module rsd_sqrt_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_v,
	output logic           in_rdy,
	input  rsd_pkg::rad_t  rad_in,
	input  rsd_pkg::rem_t  rem_in,
	input  rsd_pkg::root_t root_in,
	output logic           out_v,
	input  logic           out_rdy,
	output rsd_pkg::rad_t  rad_out,
	output rsd_pkg::rem_t  rem_out,
	output rsd_pkg::root_t root_out
);
	import rsd_pkg::*;

	logic  v_s1;
	rad_t  rad_s1;
	rem_t  rem_s1;
	root_t root_s1;
	rem_t  rem_sh, trial, rem_n;
	logic  ge;

	always_comb begin
		rem_sh = {rem_in[REMW-3:0], rad_in[RADW-1 -: 2]};
		trial = REMW'({root_in, 2'b01});
		ge = rem_sh >= trial;
		rem_n = ge ? rem_sh - trial : rem_sh;
	end

	assign in_rdy = !v_s1 || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_rdy) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_v) begin
			rad_s1 <= {rad_in[RADW-3:0], 2'b00};
			rem_s1 <= rem_n;
			root_s1 <= {root_in[RTW-2:0], ge};
		end
	end

	assign out_v = v_s1;
	assign rad_out = rad_s1;
	assign rem_out = rem_s1;
	assign root_out = root_s1;

endmodule

/* rtl/core/rsd_div3.sv */
// rsd_div3: floor division of the root by 3 via reciprocal multiply.
// Two stages: product register, then result register. Uses rsd_pkg.
`timescale 1ns / 1ps

module rsd_div3 (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_v,
	output logic           in_rdy,
	input  rsd_pkg::root_t root,
	output logic           out_v,
	input  logic           out_rdy,
	output rsd_pkg::res_t  quot
);
	import rsd_pkg::*;

	logic             v_s1, v_s2;
	logic [PRODW-1:0] prod_s1;
	res_t             quot_s2;
	logic             rdy_s2;

	assign rdy_s2 = !v_s2 || out_rdy;
	assign in_rdy = !v_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_rdy) begin
				v_s1 <= in_v;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_v) begin
			prod_s1 <= PRODW'(root) * PRODW'(DIV3_MUL);
		end
		if (rdy_s2 && v_s1) begin
			quot_s2 <= prod_s1[DIV3_SHIFT +: OUTW];
		end
	end

	assign out_v = v_s2;
	assign quot = quot_s2;

endmodule

/* rtl/core/rsd_checker.sv */
// rsd_checker: port-level assertions for rgb_saturation_std_dev.
// Bound to the top level below; uses rsd_pkg.
`timescale 1ns / 1ps

module rsd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          pixel_valid,
	input logic          pixel_stall,
	input rsd_pkg::pix_t blue,
	input rsd_pkg::pix_t green,
	input rsd_pkg::pix_t red,
	input logic          result_valid,
	input logic          result_stall,
	input rsd_pkg::res_t std_dev
);
	import rsd_pkg::*;

	localparam res_t MAX_STD = OUTW'(30773);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(std_dev))
		else $error("stalled result transaction changed");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> std_dev <= MAX_STD)
		else $error("std_dev out of range");

	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !pixel_stall)
		else $error("input stalled with output side empty");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable({blue, green, red}))
		else $error("stalled pixel transaction changed");

endmodule

bind rgb_saturation_std_dev rsd_checker u_rsd_checker (.*);
